/* design/cpra_pkg.sv */
// ----------------------------------------------------------------------------
// Contiguous page run allocator package
// Shared constants, opcodes, transfer payload types and the bit search helper.
// ----------------------------------------------------------------------------
package cpra_pkg;

    // The page map is kept as words of this many pages.
    localparam int WORD_W    = 32;
    localparam int WORD_SH   = 5;

    localparam int PAGES_DEF = 256;
    localparam int RUN_LEN_W = 9;
    localparam int PAGE_W    = 8;

    localparam logic [1:0] OP_FIND = 2'd0;
    localparam logic [1:0] OP_TAKE = 2'd1;
    localparam logic [1:0] OP_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PAGE_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] run_start;
    } rsp_t;

    // Position of the lowest set bit of a map word (zero when none is set).
    function automatic logic [WORD_SH-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [WORD_SH-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i])
            begin
                pos = WORD_SH'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* design/contiguous_page_run_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Contiguous page run allocator
// First-fit style page bitmap with find, take-run and free-run requests.
// ----------------------------------------------------------------------------
// Usage: a request transfer (req_valid, req_stall, req) carries an opcode and
// a first page. Find reports the lowest free page if the run_length pages from
// there are all free and inside the disk, and not-found otherwise without
// searching further. Take and free mark run_length pages from page_index;
// pages past the end are skipped. Every request gives one response transfer
// (rsp_valid, rsp_stall, rsp). The run length is written through cfg_we and
// cfg_data while no request is in flight.
// Sequence: the map is read one 32-page word at a time; each word is read and
// then checked. A find checks words up to the first free page, makes one bound
// check, checks the words of the run and then gives its result; a mark reads
// and writes each word it touches and then gives its result. The next request
// can be taken once the result has been loaded into the output register.
// Reset leaves every page free and the run length at 1. req_stall is high
// while a request is worked on. A stalled response waits in the output
// register; the next request is still taken and its result waits behind it.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator_unit #(
    parameter int PAGES = cpra_pkg::PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  cpra_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output cpra_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [cpra_pkg::RUN_LEN_W-1:0]  cfg_data
);

    localparam int NUM_WORDS = (PAGES + cpra_pkg::WORD_W - 1) / cpra_pkg::WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic                        res_done;
    logic                        res_take;
    cpra_pkg::rsp_t              res;
    logic [WA_W-1:0]             map_addr;
    logic [cpra_pkg::WORD_W-1:0] map_rd_data;
    logic                        map_wr_en;
    logic [cpra_pkg::WORD_W-1:0] map_wr_data;

    logic                        rsp_valid_reg;
    cpra_pkg::rsp_t              rsp_reg;

    cpra_ctrl #(
        .PAGES (PAGES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .res_done    (res_done),
        .res_take    (res_take),
        .res         (res),
        .map_addr    (map_addr),
        .map_rd_data (map_rd_data),
        .map_wr_en   (map_wr_en),
        .map_wr_data (map_wr_data)
    );

    cpra_map #(
        .PAGES (PAGES)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (map_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_addr),
        .wr_data (map_wr_data)
    );

    // The output register can load when it is empty or being emptied now.
    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_done && res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done && res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/cpra_map.sv */
// ----------------------------------------------------------------------------
// Page map storage
// Word-wide free map with one valid bit per word; an unwritten word reads as
// all pages free. Read data is registered, one write port.
// ----------------------------------------------------------------------------
module cpra_map #(
    parameter int  PAGES     = cpra_pkg::PAGES_DEF,
    localparam int NUM_WORDS = (PAGES + cpra_pkg::WORD_W - 1) / cpra_pkg::WORD_W,
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [WA_W-1:0]               rd_addr,
    output logic [cpra_pkg::WORD_W-1:0]   rd_data,
    input  logic                          wr_en,
    input  logic [WA_W-1:0]               wr_addr,
    input  logic [cpra_pkg::WORD_W-1:0]   wr_data
);

    logic [cpra_pkg::WORD_W-1:0] words_reg [NUM_WORDS];
    logic [NUM_WORDS-1:0]        valid_reg;
    logic [cpra_pkg::WORD_W-1:0] rd_word_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            words_reg[wr_addr] <= wr_data;
        end
        rd_word_reg <= words_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '1;

endmodule

/* design/cpra_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the page map one word at a time through a shared range mask and
// compare unit, for both the free page search and run check or marking.
// ----------------------------------------------------------------------------
module cpra_ctrl #(
    parameter int  PAGES     = cpra_pkg::PAGES_DEF,
    localparam int NUM_WORDS = (PAGES + cpra_pkg::WORD_W - 1) / cpra_pkg::WORD_W,
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  cpra_pkg::req_t                  req,
    input  logic                            cfg_we,
    input  logic [cpra_pkg::RUN_LEN_W-1:0]  cfg_data,
    output logic                            res_done,
    input  logic                            res_take,
    output cpra_pkg::rsp_t                  res,
    output logic [WA_W-1:0]                 map_addr,
    input  logic [cpra_pkg::WORD_W-1:0]     map_rd_data,
    output logic                            map_wr_en,
    output logic [cpra_pkg::WORD_W-1:0]     map_wr_data
);

    localparam int POS_W     = $clog2(PAGES + 512);
    localparam int SH        = cpra_pkg::WORD_SH;

    localparam logic [POS_W-1:0] PAGES_P   = POS_W'(PAGES);
    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(NUM_WORDS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FRD   = 3'd1;
    localparam logic [2:0] S_FCHK  = 3'd2;
    localparam logic [2:0] S_BOUND = 3'd3;
    localparam logic [2:0] S_RRD   = 3'd4;
    localparam logic [2:0] S_RCHK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [WA_W-1:0]                word_reg, word_next;
    logic [POS_W-1:0]               start_reg, start_next;
    logic [POS_W-1:0]               end_reg, end_next;
    logic                           found_reg, found_next;
    logic [cpra_pkg::RUN_LEN_W-1:0] run_len_reg;

    logic [POS_W-1:0]               add_a, sum;
    logic [POS_W-1:0]               base;
    logic [POS_W-1:0]               m_start, m_end;
    logic [POS_W-1:0]               lo_diff, hi_diff, end_m1;
    logic [SH-1:0]                  lo;
    logic                           hi_full;
    logic [cpra_pkg::WORD_W-1:0]    mask, masked;
    logic [WA_W-1:0]                last_run;
    logic                           len_zero;
    logic                           accept;

    // Shared adder: request page plus run length, or found page plus run length.
    assign add_a    = (state_reg == S_IDLE) ? POS_W'(req.page_index) : start_reg;
    assign sum      = add_a + POS_W'(run_len_reg);
    assign len_zero = (run_len_reg == '0);

    // Shared range mask unit over the current word: pages in [m_start, m_end).
    assign base    = POS_W'({word_reg, {SH{1'b0}}});
    assign m_start = (state_reg == S_FCHK) ? '0 : start_reg;
    assign m_end   = (state_reg == S_FCHK) ? PAGES_P : end_reg;
    assign lo_diff = m_start - base;
    assign hi_diff = m_end - base;
    assign lo      = (m_start > base) ? lo_diff[SH-1:0] : '0;
    assign hi_full = (hi_diff >= POS_W'(cpra_pkg::WORD_W));
    assign mask    = ({cpra_pkg::WORD_W{1'b1}} << lo)
                   & (hi_full ? {cpra_pkg::WORD_W{1'b1}}
                              : ~({cpra_pkg::WORD_W{1'b1}} << hi_diff[SH-1:0]));
    assign masked  = map_rd_data & mask;

    assign end_m1   = end_reg - POS_W'(1);
    assign last_run = end_m1[WA_W+SH-1:SH];

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign res_done  = (state_reg == S_DONE);
    assign map_addr  = word_reg;

    always_comb
    begin
        res.found     = found_reg;
        res.run_start = (op_reg == cpra_pkg::OP_FIND && found_reg)
                      ? start_reg[cpra_pkg::PAGE_W-1:0] : '0;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        word_next   = word_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        found_next  = found_reg;
        map_wr_en   = 1'b0;
        map_wr_data = map_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = req.opcode;
                    case (req.opcode)
                        cpra_pkg::OP_FIND:
                        begin
                            word_next  = '0;
                            state_next = S_FRD;
                        end
                        cpra_pkg::OP_TAKE, cpra_pkg::OP_FREE:
                        begin
                            found_next = 1'b1;
                            if (len_zero || POS_W'(req.page_index) >= PAGES_P)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                start_next = POS_W'(req.page_index);
                                end_next   = (sum > PAGES_P) ? PAGES_P : sum;
                                word_next  = WA_W'(req.page_index >> SH);
                                state_next = S_RRD;
                            end
                        end
                        default:
                        begin
                            found_next = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (|masked)
                begin
                    start_next = base + POS_W'(cpra_pkg::lowest_set(masked));
                    state_next = S_BOUND;
                end
                else if (word_reg == LAST_WORD)
                begin
                    found_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WA_W'(1);
                    state_next = S_FRD;
                end
            end
            S_BOUND:
            begin
                // The word that holds the found page is still selected.
                if (len_zero)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (sum > PAGES_P)
                begin
                    found_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    end_next   = sum;
                    state_next = S_RRD;
                end
            end
            S_RRD:
            begin
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (op_reg == cpra_pkg::OP_TAKE)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_data = map_rd_data & ~mask;
                end
                else if (op_reg == cpra_pkg::OP_FREE)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_data = map_rd_data | mask;
                end

                if (op_reg == cpra_pkg::OP_FIND && masked != mask)
                begin
                    found_next = 1'b0;
                    state_next = S_DONE;
                end
                else if (word_reg == last_run)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WA_W'(1);
                    state_next = S_RRD;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            run_len_reg <= cpra_pkg::RUN_LEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                run_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        word_reg  <= word_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        found_reg <= found_next;
    end

endmodule

/* design/cpra_checker.sv */
// ----------------------------------------------------------------------------
// Allocator port checker
// Concurrent checks on the top level ports, attached through a bind.
// ----------------------------------------------------------------------------
module cpra_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input cpra_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input cpra_pkg::rsp_t rsp
);

    // A held response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A stalled request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed");

    // A not-found response (a failed find or an unused opcode) never reports a start page other than zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.run_start == '0)
        else $error("not-found response with nonzero run start");

    // Each request transfer is followed by a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken without going busy");

    // A response only appears after the block has been working on a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared while idle");

endmodule

bind contiguous_page_run_allocator_unit cpra_checker u_cpra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Contiguous page run allocator testbench
// Drives find, take and free requests through the valid/stall request channel
// and checks every response against a page map kept in the testbench. The run
// length is changed between phases, including zero and the 9-bit extremes,
// and both channels idle at random in most phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PAGES        = cpra_pkg::PAGES_DEF;
    localparam int PAGE_W       = cpra_pkg::PAGE_W;
    localparam int RUN_LEN_W    = cpra_pkg::RUN_LEN_W;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // Opcode 3 has no meaning; the block must answer it as not found.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // How a queued request gets its page index when it is sent.
    typedef enum logic [1:0] {
        JOB_PLAIN,
        JOB_TAKE_FOUND,
        JOB_FREE_HELD
    } job_kind_t;

    typedef struct {
        cpra_pkg::req_t r;
        job_kind_t      kind;
    } job_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    cpra_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    cpra_pkg::rsp_t rsp;
    logic           cfg_we    = 1'b0;
    logic [RUN_LEN_W-1:0] cfg_data = '0;

    // Testbench copy of the block state.
    logic [PAGES-1:0]     page_free = '1;
    logic [RUN_LEN_W-1:0] run_pages = 9'd1;

    job_t              request_backlog[$];
    cpra_pkg::rsp_t    expected_replies[$];
    logic [PAGE_W-1:0] held_runs[$];
    logic              last_find_ok    = 1'b0;
    logic [PAGE_W-1:0] last_found_page = '0;

    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             errors        = 0;
    int             cycle_count   = 0;
    cpra_pkg::rsp_t want;

    contiguous_page_run_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Applies one accepted request to the page map and returns its response.
    function automatic cpra_pkg::rsp_t apply_page_request(input cpra_pkg::req_t r);
        cpra_pkg::rsp_t res;
        int   first;
        int   k;
        logic fits;
        res = '0;
        case (r.opcode)
            cpra_pkg::OP_FIND:
            begin
                first = -1;
                for (k = 0; k < PAGES; k++)
                begin
                    if (page_free[k])
                    begin
                        first = k;
                        break;
                    end
                end
                fits = (first >= 0);
                if (fits)
                begin
                    for (k = 0; k < int'(run_pages); k++)
                    begin
                        if (first + k >= PAGES || !page_free[first + k])
                        begin
                            fits = 1'b0;
                        end
                    end
                end
                if (fits)
                begin
                    res.found     = 1'b1;
                    res.run_start = PAGE_W'(first);
                end
                last_find_ok    = fits;
                last_found_page = res.run_start;
            end
            cpra_pkg::OP_TAKE, cpra_pkg::OP_FREE:
            begin
                for (k = 0; k < int'(run_pages); k++)
                begin
                    if (int'(r.page_index) + k < PAGES)
                    begin
                        page_free[int'(r.page_index) + k] = (r.opcode == cpra_pkg::OP_FREE);
                    end
                end
                res.found = 1'b1;
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // Fills in the page index of a queued request at the moment it is sent.
    // A take that follows a failed find turns into a free of a held run, so
    // the map keeps cycling between full and empty.
    function automatic cpra_pkg::req_t resolve_job(input job_t j);
        cpra_pkg::req_t r;
        int             pick;
        r = j.r;
        if (j.kind == JOB_TAKE_FOUND)
        begin
            if (last_find_ok)
            begin
                r.opcode     = cpra_pkg::OP_TAKE;
                r.page_index = last_found_page;
                held_runs.push_back(last_found_page);
            end
            else if (held_runs.size() > 0)
            begin
                pick         = $urandom_range(held_runs.size() - 1);
                r.opcode     = cpra_pkg::OP_FREE;
                r.page_index = held_runs[pick];
                held_runs.delete(pick);
            end
            else
            begin
                r.opcode     = cpra_pkg::OP_TAKE;
                r.page_index = PAGE_W'($urandom_range(PAGES - 1));
            end
        end
        else if (j.kind == JOB_FREE_HELD)
        begin
            r.opcode = cpra_pkg::OP_FREE;
            if (held_runs.size() > 0)
            begin
                pick         = $urandom_range(held_runs.size() - 1);
                r.page_index = held_runs[pick];
                held_runs.delete(pick);
            end
            else
            begin
                r.page_index = PAGE_W'($urandom_range(PAGES - 1));
            end
        end
        return r;
    endfunction

    // Request driver: the expectation is computed when the transfer happens.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_replies.push_back(apply_page_request(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= resolve_job(request_backlog.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected response: found %0d run_start %0d",
                           rsp.found, rsp.run_start);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.run_start !== want.run_start)
                    begin
                        $error("run_start: expected %0d, got %0d",
                               want.run_start, rsp.run_start);
                        errors++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("contiguous_page_run_allocator_unit test failed");
            $finish;
        end
    end

    task automatic push_plain(input logic [1:0] op, input logic [PAGE_W-1:0] page);
        job_t j;
        j.r.opcode     = op;
        j.r.page_index = page;
        j.kind         = JOB_PLAIN;
        request_backlog.push_back(j);
    endtask

    task automatic push_kind(input job_kind_t kind);
        job_t j;
        j.r    = '0;
        j.kind = kind;
        request_backlog.push_back(j);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (request_backlog.size() != 0 || req_valid || expected_replies.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // The run length is only written with nothing in flight.
    task automatic set_run_length(input logic [RUN_LEN_W-1:0] len);
        wait_idle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        run_pages = len;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly find-then-take pairs and frees of held runs, with some noise.
    task automatic fill_random(input int count);
        int made;
        int roll;
        made = 0;
        while (made < count)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                push_plain(cpra_pkg::OP_FIND, PAGE_W'($urandom_range(PAGES - 1)));
                push_kind(JOB_TAKE_FOUND);
                made += 2;
            end
            else if (roll < 80)
            begin
                push_kind(JOB_FREE_HELD);
                made++;
            end
            else
            begin
                push_plain(2'($urandom_range(3)), PAGE_W'($urandom_range(PAGES - 1)));
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 46;

        // Reset run length of one page.
        push_plain(cpra_pkg::OP_FIND, 8'hFF);
        push_plain(cpra_pkg::OP_TAKE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_TAKE, 8'hFF);
        push_plain(cpra_pkg::OP_FREE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(OP_UNUSED, 8'hFF);
        push_plain(cpra_pkg::OP_FIND, 8'h00);

        // Zero length: finds succeed, marks change nothing.
        set_run_length(9'd0);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_TAKE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);

        // Whole disk: the run hits the taken last page, then no free page at all,
        // then a run that would go past the end.
        set_run_length(9'd256);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_FREE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_TAKE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_FREE, 8'h80);
        push_plain(cpra_pkg::OP_FIND, 8'h00);

        set_run_length(9'd511);
        push_plain(cpra_pkg::OP_FREE, 8'h00);
        push_plain(cpra_pkg::OP_FIND, 8'h00);
        push_plain(cpra_pkg::OP_TAKE, 8'hFF);

        set_run_length(9'd1);
        fill_random(120);
        set_run_length(9'd3);
        fill_random(100);

        wait_idle();
        send_idle_pct = 46;
        recv_idle_pct = 37;
        set_run_length(9'd8);
        fill_random(100);
        set_run_length(9'd0);
        fill_random(20);
        set_run_length(9'd256);
        fill_random(15);
        set_run_length(9'd511);
        fill_random(15);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_run_length(9'd2);
        fill_random(100);
        set_run_length(9'd5);
        fill_random(80);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
        begin
            $display("contiguous_page_run_allocator_unit test passed");
        end
        else
        begin
            $display("contiguous_page_run_allocator_unit test failed");
        end
        $finish;
    end

endmodule
